>>> sv/nchk_pkg.sv
package nchk_pkg;

   // Nesting depth limit; the counters are eight bits wide, so the cap never exceeds 255.
   localparam int unsigned MAX_DEPTH = 255;
   localparam int unsigned CAP_VALUE = (MAX_DEPTH < 255) ? MAX_DEPTH : 255;

   localparam int unsigned CHAR_W   = 8;
   localparam int unsigned DEPTH_W  = 8;
   localparam int unsigned ERR_W    = 3;
   localparam int unsigned CSR_IDX_W = 3;

   localparam logic [DEPTH_W-1:0] DEPTH_CAP  = DEPTH_W'(CAP_VALUE);
   localparam logic [DEPTH_W-1:0] DEPTH_ZERO = '0;
   localparam logic [DEPTH_W-1:0] DEPTH_ONE  = DEPTH_W'(1);

   // Register indexes of the configuration port.
   localparam logic [CSR_IDX_W-1:0] CSR_SECTION_OPEN  = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_SECTION_CLOSE = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] CSR_VECTOR_OPEN   = CSR_IDX_W'(2);
   localparam logic [CSR_IDX_W-1:0] CSR_VECTOR_CLOSE  = CSR_IDX_W'(3);
   localparam logic [CSR_IDX_W-1:0] CSR_DELIMITER     = CSR_IDX_W'(4);

   // Reset values of the character registers.
   localparam logic [CHAR_W-1:0] RST_SECTION_OPEN  = 8'd123;
   localparam logic [CHAR_W-1:0] RST_SECTION_CLOSE = 8'd125;
   localparam logic [CHAR_W-1:0] RST_VECTOR_OPEN   = 8'd91;
   localparam logic [CHAR_W-1:0] RST_VECTOR_CLOSE  = 8'd93;
   localparam logic [CHAR_W-1:0] RST_DELIMITER     = 8'd59;

   typedef enum logic [ERR_W-1:0] {
      ERR_NONE             = 3'd0,
      ERR_SEC_OPEN_IN_VEC  = 3'd1,
      ERR_EXTRA_SEC_CLOSE  = 3'd2,
      ERR_SEC_CLOSE_IN_VEC = 3'd3,
      ERR_EXTRA_VEC_CLOSE  = 3'd4,
      ERR_UNRESOLVED_SEC   = 3'd5,
      ERR_UNRESOLVED_VEC   = 3'd6,
      ERR_OVERFLOW         = 3'd7
   } err_type;

   typedef struct packed {
      logic [CHAR_W-1:0] section_open;
      logic [CHAR_W-1:0] section_close;
      logic [CHAR_W-1:0] vector_open;
      logic [CHAR_W-1:0] vector_close;
      logic [CHAR_W-1:0] delimiter;
   } cfg_type;

   typedef struct packed {
      logic               split_here;
      logic [DEPTH_W-1:0] section_depth_now;
      logic [DEPTH_W-1:0] vector_depth_now;
      err_type            error_code;
      logic               text_done;
   } result_type;

endpackage

>>> sv/nchk_if.sv
// Input channel: one text byte per word.
interface nchk_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] text_byte;
   logic       end_of_text;

   modport source (output valid, output text_byte, output end_of_text, input ready);
   modport sink   (input valid, input text_byte, input end_of_text, output ready);
endinterface

// Result channel: one word per accepted byte.
interface nchk_rsp_if;
   logic       valid;
   logic       ready;
   logic       split_here;
   logic [7:0] section_depth_now;
   logic [7:0] vector_depth_now;
   logic [2:0] error_code;
   logic       text_done;

   modport source (output valid, output split_here, output section_depth_now,
                   output vector_depth_now, output error_code, output text_done,
                   input ready);
   modport sink   (input valid, input split_here, input section_depth_now,
                   input vector_depth_now, input error_code, input text_done,
                   output ready);
endinterface

// Configuration write channel.
interface nchk_csr_if;
   logic       valid;
   logic       ready;
   logic [2:0] index;
   logic [7:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

>>> sv/nesting_checker_and_top_level_splitter.sv
// Bracket nesting checker and top-level splitter. Each byte accepted on the req_chan
// channel yields exactly one word on rsp_chan carrying the split flag, both nesting
// depths after the byte, the first error of the current text and an echo of the
// end-of-text mark. A byte is captured in an input register, evaluated against the
// depth state combinationally and held in a result register, so the block takes one
// byte per cycle unless rsp_chan stalls, and offers the result word from the result
// register once the byte moves on from the input register. The open, close and
// delimiter characters are set through csr_chan and should only be changed while no
// byte is in flight. After the word marked last has been produced, depths and error clear.
module nesting_checker_and_top_level_splitter
   import nchk_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   nchk_req_if.sink    req_chan,
   nchk_rsp_if.source  rsp_chan,
   nchk_csr_if.sink    csr_chan
);

   cfg_type    cfg;
   result_type result;

   logic              in_valid_ff;
   logic [CHAR_W-1:0] in_byte_ff;
   logic              in_last_ff;
   logic              out_valid_ff;
   result_type        out_word_ff;
   logic              advance;

   nchk_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .csr_chan (csr_chan),
      .cfg      (cfg)
   );

   // A byte moves on when the result register is empty or being emptied.
   assign advance        = in_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !in_valid_ff || advance;

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         in_valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.ready && req_chan.valid) begin
         in_byte_ff <= req_chan.text_byte;
         in_last_ff <= req_chan.end_of_text;
      end
   end

   nchk_tracker u_tracker (
      .clock       (clock),
      .reset       (reset),
      .step        (advance),
      .text_byte   (in_byte_ff),
      .end_of_text (in_last_ff),
      .cfg         (cfg),
      .result      (result)
   );

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_word_ff <= result;
      end
   end

   assign rsp_chan.valid             = out_valid_ff;
   assign rsp_chan.split_here        = out_word_ff.split_here;
   assign rsp_chan.section_depth_now = out_word_ff.section_depth_now;
   assign rsp_chan.vector_depth_now  = out_word_ff.vector_depth_now;
   assign rsp_chan.error_code        = out_word_ff.error_code;
   assign rsp_chan.text_done         = out_word_ff.text_done;

endmodule

>>> sv/nchk_csr.sv
module nchk_csr
   import nchk_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   nchk_csr_if.sink   csr_chan,
   output cfg_type    cfg
);

   cfg_type cfg_ff;

   // Writes are always taken; an index beyond the register list is ignored.
   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.section_open  <= RST_SECTION_OPEN;
         cfg_ff.section_close <= RST_SECTION_CLOSE;
         cfg_ff.vector_open   <= RST_VECTOR_OPEN;
         cfg_ff.vector_close  <= RST_VECTOR_CLOSE;
         cfg_ff.delimiter     <= RST_DELIMITER;
      end else if (csr_chan.valid) begin
         case (csr_chan.index)
            CSR_SECTION_OPEN:  cfg_ff.section_open  <= csr_chan.data;
            CSR_SECTION_CLOSE: cfg_ff.section_close <= csr_chan.data;
            CSR_VECTOR_OPEN:   cfg_ff.vector_open   <= csr_chan.data;
            CSR_VECTOR_CLOSE:  cfg_ff.vector_close  <= csr_chan.data;
            CSR_DELIMITER:     cfg_ff.delimiter     <= csr_chan.data;
            default: ;
         endcase
      end
   end

   assign cfg = cfg_ff;

endmodule

>>> sv/nchk_tracker.sv
module nchk_tracker
   import nchk_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              step,
   input  logic [CHAR_W-1:0] text_byte,
   input  logic              end_of_text,
   input  cfg_type           cfg,
   output result_type        result
);

   logic [DEPTH_W-1:0] section_depth_ff, section_depth_in;
   logic [DEPTH_W-1:0] vector_depth_ff, vector_depth_in;
   err_type            error_ff, error_in;

   logic [DEPTH_W-1:0] sec_now;
   logic [DEPTH_W-1:0] vec_now;
   err_type            err_now;
   logic               split_now;

   // Apply the four bracket checks in fixed order; only the first error of a text is kept.
   always_comb begin
      sec_now = section_depth_ff;
      vec_now = vector_depth_ff;
      err_now = error_ff;

      if (text_byte == cfg.section_open) begin
         if (sec_now >= DEPTH_CAP) begin
            if (err_now == ERR_NONE) err_now = ERR_OVERFLOW;
         end else begin
            sec_now = sec_now + DEPTH_ONE;
            if (vec_now != DEPTH_ZERO && err_now == ERR_NONE) err_now = ERR_SEC_OPEN_IN_VEC;
         end
      end

      if (text_byte == cfg.section_close) begin
         if (sec_now == DEPTH_ZERO) begin
            if (err_now == ERR_NONE) err_now = ERR_EXTRA_SEC_CLOSE;
         end else begin
            sec_now = sec_now - DEPTH_ONE;
            if (vec_now != DEPTH_ZERO && err_now == ERR_NONE) err_now = ERR_SEC_CLOSE_IN_VEC;
         end
      end

      if (text_byte == cfg.vector_open) begin
         if (vec_now >= DEPTH_CAP) begin
            if (err_now == ERR_NONE) err_now = ERR_OVERFLOW;
         end else begin
            vec_now = vec_now + DEPTH_ONE;
         end
      end

      if (text_byte == cfg.vector_close) begin
         if (vec_now == DEPTH_ZERO) begin
            if (err_now == ERR_NONE) err_now = ERR_EXTRA_VEC_CLOSE;
         end else begin
            vec_now = vec_now - DEPTH_ONE;
         end
      end

      split_now = (text_byte == cfg.delimiter) && (sec_now == DEPTH_ZERO)
                  && (vec_now == DEPTH_ZERO);

      // Openers still pending at the last byte of the text.
      if (end_of_text && err_now == ERR_NONE) begin
         if (sec_now != DEPTH_ZERO) begin
            err_now = ERR_UNRESOLVED_SEC;
         end else if (vec_now != DEPTH_ZERO) begin
            err_now = ERR_UNRESOLVED_VEC;
         end
      end
   end

   // The state clears after the last byte so the next text starts fresh.
   always_comb begin
      section_depth_in = end_of_text ? DEPTH_ZERO : sec_now;
      vector_depth_in  = end_of_text ? DEPTH_ZERO : vec_now;
      error_in         = end_of_text ? ERR_NONE : err_now;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         section_depth_ff <= DEPTH_ZERO;
         vector_depth_ff  <= DEPTH_ZERO;
         error_ff         <= ERR_NONE;
      end else if (step) begin
         section_depth_ff <= section_depth_in;
         vector_depth_ff  <= vector_depth_in;
         error_ff         <= error_in;
      end
   end

   assign result.split_here        = split_now;
   assign result.section_depth_now = sec_now;
   assign result.vector_depth_now  = vec_now;
   assign result.error_code        = err_now;
   assign result.text_done         = end_of_text;

endmodule

>>> sv/nchk_checker.sv
module nchk_checker
   import nchk_pkg::*;
(
   input logic               clock,
   input logic               reset,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic               split_here,
   input logic [DEPTH_W-1:0] section_depth_now,
   input logic [DEPTH_W-1:0] vector_depth_now,
   input logic [ERR_W-1:0]   error_code,
   input logic               text_done
);

   // A split point only occurs with both depths at zero.
   a_split_at_top: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && split_here |-> section_depth_now == DEPTH_ZERO
                                  && vector_depth_now == DEPTH_ZERO)
      else $error("split reported inside a bracket");

   // A text that ends clean has closed every opener.
   a_clean_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && text_done && error_code == ERR_NONE
         |-> section_depth_now == DEPTH_ZERO && vector_depth_now == DEPTH_ZERO)
      else $error("text ended with open brackets but no error");

   // Unresolved-opener errors only appear on the last word of a text.
   a_unresolved_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (error_code == ERR_UNRESOLVED_SEC || error_code == ERR_UNRESOLVED_VEC)
         |-> text_done)
      else $error("unresolved-opener error before end of text");

   // A stalled result word stays put.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(split_here)
         && $stable(section_depth_now) && $stable(vector_depth_now)
         && $stable(error_code) && $stable(text_done))
      else $error("result word changed while stalled");

endmodule

bind nesting_checker_and_top_level_splitter nchk_checker u_nchk_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_chan.valid),
   .rsp_ready         (rsp_chan.ready),
   .split_here        (rsp_chan.split_here),
   .section_depth_now (rsp_chan.section_depth_now),
   .vector_depth_now  (rsp_chan.vector_depth_now),
   .error_code        (rsp_chan.error_code),
   .text_done         (rsp_chan.text_done)
);

>>> test/tb.sv
`timescale 1ns / 100ps

module tb;
   import nchk_pkg::*;

   localparam int unsigned LONG_HOLD_CYCLES = 250;
   localparam int unsigned QUIET_LIMIT      = 2000;
   localparam int unsigned SETTLE_CYCLES    = 8;
   localparam int unsigned PHASE_WORDS      = 90;

   localparam cfg_type DEFAULT_CHARS = '{RST_SECTION_OPEN, RST_SECTION_CLOSE,
                                         RST_VECTOR_OPEN, RST_VECTOR_CLOSE,
                                         RST_DELIMITER};

   logic clock = 1'b0;
   logic reset;

   nchk_req_if req_chan ();
   nchk_rsp_if rsp_chan ();
   nchk_csr_if csr_chan ();

   nesting_checker_and_top_level_splitter dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   // Pacing controls shared by the sender and the receiver.
   bit          idling_on         = 1'b1;
   bit          long_hold_pending = 1'b0;
   int unsigned long_hold_left    = 0;
   int unsigned stall_left        = 0;
   int unsigned quiet_cycles      = 0;
   int unsigned mismatch_count    = 0;
   int unsigned words_sent        = 0;

   // Expected result words, oldest first, and the tracked nesting state.
   result_type   expected_words [$];
   cfg_type      chars;
   logic [7:0]   section_level;
   logic [7:0]   vector_level;
   err_type      text_error;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Only the first error of a text is kept.
   function automatic void note_error(input err_type code);
      if (text_error == ERR_NONE) begin
         text_error = code;
      end
   endfunction

   // Applies one byte to the tracked depths and returns the word the block should report.
   function automatic result_type scan_byte(input logic [7:0] b, input logic last);
      result_type w;
      if (b == chars.section_open) begin
         if (section_level >= DEPTH_CAP) begin
            note_error(ERR_OVERFLOW);
         end else begin
            section_level++;
            if (vector_level != 0) begin
               note_error(ERR_SEC_OPEN_IN_VEC);
            end
         end
      end
      if (b == chars.section_close) begin
         if (section_level == 0) begin
            note_error(ERR_EXTRA_SEC_CLOSE);
         end else begin
            section_level--;
            if (vector_level != 0) begin
               note_error(ERR_SEC_CLOSE_IN_VEC);
            end
         end
      end
      if (b == chars.vector_open) begin
         if (vector_level >= DEPTH_CAP) begin
            note_error(ERR_OVERFLOW);
         end else begin
            vector_level++;
         end
      end
      if (b == chars.vector_close) begin
         if (vector_level == 0) begin
            note_error(ERR_EXTRA_VEC_CLOSE);
         end else begin
            vector_level--;
         end
      end
      w.split_here = (b == chars.delimiter) && section_level == 0 && vector_level == 0;
      if (last) begin
         if (section_level != 0) begin
            note_error(ERR_UNRESOLVED_SEC);
         end else if (vector_level != 0) begin
            note_error(ERR_UNRESOLVED_VEC);
         end
      end
      w.section_depth_now = section_level;
      w.vector_depth_now  = vector_level;
      w.error_code        = text_error;
      w.text_done         = last;
      // The text has ended: the next byte starts from a clean state.
      if (last) begin
         section_level = DEPTH_ZERO;
         vector_level  = DEPTH_ZERO;
         text_error    = ERR_NONE;
      end
      return w;
   endfunction

   // Offers one byte, possibly after an idle burst, and records its expected word.
   task automatic send_word(input logic [7:0] b, input logic last);
      if (idling_on && $urandom_range(0, 9) == 0) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 18)) @(posedge clock);
      end
      req_chan.valid       <= 1'b1;
      req_chan.text_byte   <= b;
      req_chan.end_of_text <= last;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      expected_words = {expected_words, scan_byte(b, last)};
      words_sent++;
   endtask

   task automatic send_chars(input string s);
      int i;
      for (i = 0; i < s.len(); i++) begin
         send_word(s[i], i == s.len() - 1);
      end
   endtask

   // Stops offering and waits until every expected word has come back.
   task automatic drain_results();
      req_chan.valid <= 1'b0;
      while (expected_words.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input logic [CSR_IDX_W-1:0] idx, input logic [7:0] value);
      csr_chan.valid <= 1'b1;
      csr_chan.index <= idx;
      csr_chan.data  <= value;
      @(posedge clock);
      while (!csr_chan.ready) @(posedge clock);
      case (idx)
         CSR_SECTION_OPEN:  chars.section_open  = value;
         CSR_SECTION_CLOSE: chars.section_close = value;
         CSR_VECTOR_OPEN:   chars.vector_open   = value;
         CSR_VECTOR_CLOSE:  chars.vector_close  = value;
         CSR_DELIMITER:     chars.delimiter     = value;
         default: ;
      endcase
   endtask

   // Writes all five character registers; call only once the block is idle.
   task automatic load_chars(input cfg_type c);
      write_register(CSR_SECTION_OPEN, c.section_open);
      write_register(CSR_SECTION_CLOSE, c.section_close);
      write_register(CSR_VECTOR_OPEN, c.vector_open);
      write_register(CSR_VECTOR_CLOSE, c.vector_close);
      write_register(CSR_DELIMITER, c.delimiter);
      csr_chan.valid <= 1'b0;
   endtask

   function automatic logic [7:0] any_special_char();
      case ($urandom_range(0, 4))
         0:       return chars.section_open;
         1:       return chars.section_close;
         2:       return chars.vector_open;
         3:       return chars.vector_close;
         default: return chars.delimiter;
      endcase
   endfunction

   // Builds a text of random content. A well-formed text keeps sections out of
   // vectors and closes everything it opens; a broken one scatters stray
   // brackets and may leave openers unresolved.
   task automatic send_generated_text(input bit broken);
      logic [7:0]  text [$];
      int unsigned open_sections;
      int unsigned open_vectors;
      int unsigned length;
      int unsigned n;
      int unsigned pick;
      open_sections = 0;
      open_vectors  = 0;
      length = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 16);
      for (n = 0; n < length; n++) begin
         pick = $urandom_range(0, 99);
         if (broken && pick < 10) begin
            text = {text, any_special_char()};
         end else if (pick < 25) begin
            if (open_vectors == 0 && $urandom_range(0, 1) == 1) begin
               text = {text, chars.section_open};
               open_sections++;
            end else begin
               text = {text, chars.vector_open};
               open_vectors++;
            end
         end else if (pick < 45) begin
            if (open_vectors != 0) begin
               text = {text, chars.vector_close};
               open_vectors--;
            end else if (open_sections != 0) begin
               text = {text, chars.section_close};
               open_sections--;
            end else begin
               text = {text, chars.delimiter};
            end
         end else if (pick < 60) begin
            text = {text, chars.delimiter};
         end else begin
            text = {text, 8'($urandom_range(0, 255))};
         end
      end
      if (!broken || $urandom_range(0, 1) == 0) begin
         repeat (open_vectors) text = {text, chars.vector_close};
         repeat (open_sections) text = {text, chars.section_close};
      end
      if (text.size() == 0) begin
         text = {text, chars.delimiter};
      end
      for (n = 0; n < text.size(); n++) begin
         send_word(text[n], n == text.size() - 1);
      end
   endtask

   // Loose bytes with the end mark set at random, so texts run into each other.
   task automatic send_noise(input int unsigned count);
      int unsigned n;
      for (n = 0; n < count; n++) begin
         send_word(($urandom_range(0, 1) == 1) ? any_special_char() : 8'($urandom_range(0, 255)),
                   $urandom_range(0, 7) == 0);
      end
   endtask

   // Splits, clean nesting and every error kind but overflow with the reset characters.
   task automatic test_default_chars();
      send_chars("x;y");
      send_chars(";");
      send_chars("[;]{;}");
      send_chars("[{");
      send_chars("{[}]");
      send_chars("[}]");
      send_chars("}");
      send_chars("]");
      send_chars("{");
      send_chars("{[");
      send_chars("[");
   endtask

   // Both depths driven to the cap; a section opener at the cap inside a vector
   // must report overflow rather than an opener inside a vector.
   task automatic test_depth_overflow();
      repeat (255) send_word(RST_SECTION_OPEN, 1'b0);
      send_word(RST_VECTOR_OPEN, 1'b0);
      send_word(RST_SECTION_OPEN, 1'b1);
      repeat (255) send_word(RST_VECTOR_OPEN, 1'b0);
      send_word(RST_VECTOR_OPEN, 1'b1);
      drain_results();
   endtask

   // Registers holding the same byte, so that one byte triggers several actions.
   task automatic test_shared_chars();
      cfg_type     shared_sets [0:3];
      int unsigned s;
      int unsigned n;
      shared_sets[0] = '{default: 8'h00};
      shared_sets[1] = '{default: 8'hFF};
      shared_sets[2] = '{section_open: 8'h41, section_close: 8'h42, vector_open: 8'h41,
                         vector_close: 8'h42, delimiter: 8'h41};
      shared_sets[3] = '{section_open: 8'h28, section_close: 8'h29, vector_open: 8'h29,
                         vector_close: 8'h28, delimiter: 8'h29};
      for (s = 0; s < 4; s++) begin
         load_chars(shared_sets[s]);
         for (n = 0; n < 10; n++) begin
            send_word(($urandom_range(0, 3) != 0) ? any_special_char()
                                                  : 8'($urandom_range(0, 255)), n == 9);
         end
         drain_results();
      end
   endtask

   // The receiver holds off for a long stretch while bytes keep coming.
   task automatic test_backpressure();
      int unsigned start;
      load_chars(DEFAULT_CHARS);
      idling_on = 1'b0;
      long_hold_pending <= 1'b1;
      start = words_sent;
      while (words_sent - start < 40) begin
         send_generated_text(1'b0);
      end
      idling_on = 1'b1;
      drain_results();
   endtask

   // Random texts over several character settings; the last setting runs without idling.
   task automatic test_random_texts();
      cfg_type     c;
      int unsigned phase;
      int unsigned start;
      int unsigned pick;
      for (phase = 0; phase < 7; phase++) begin
         if (phase == 0) begin
            c = DEFAULT_CHARS;
         end else if (phase == 1) begin
            c = '{section_open: 8'h00, section_close: 8'hFF, vector_open: 8'h80,
                  vector_close: 8'h7F, delimiter: 8'h01};
         end else begin
            c.section_open  = 8'($urandom_range(0, 255));
            c.section_close = 8'($urandom_range(0, 255));
            c.vector_open   = 8'($urandom_range(0, 255));
            c.vector_close  = 8'($urandom_range(0, 255));
            c.delimiter     = 8'($urandom_range(0, 255));
         end
         load_chars(c);
         idling_on = (phase != 6);
         start = words_sent;
         while (words_sent - start < PHASE_WORDS) begin
            pick = $urandom_range(0, 9);
            if (pick < 7) begin
               send_generated_text(1'b0);
            end else if (pick < 9) begin
               send_generated_text(1'b1);
            end else begin
               send_noise($urandom_range(1, 12));
            end
         end
         drain_results();
      end
   endtask

   // Receiver pacing: the long hold first, then random stall bursts.
   always @(posedge clock) begin
      if (long_hold_left != 0) begin
         long_hold_left <= long_hold_left - 1;
         rsp_chan.ready <= 1'b0;
      end else if (long_hold_pending) begin
         long_hold_pending <= 1'b0;
         long_hold_left    <= LONG_HOLD_CYCLES - 1;
         rsp_chan.ready    <= 1'b0;
      end else if (stall_left != 0) begin
         stall_left     <= stall_left - 1;
         rsp_chan.ready <= 1'b0;
      end else if (idling_on && $urandom_range(0, 11) == 0) begin
         stall_left     <= $urandom_range(1, 18) - 1;
         rsp_chan.ready <= 1'b0;
      end else begin
         rsp_chan.ready <= 1'b1;
      end
   end

   task automatic compare_field(input string field, input int unsigned want,
                                input int unsigned got);
      if (want != got) begin
         $display("%0t: %s mismatch: expected %0d, actual %0d", $time, field, want, got);
         mismatch_count++;
      end
   endtask

   // Every result word is checked against the oldest expectation.
   always @(posedge clock) begin : result_checker
      result_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (expected_words.size() == 0) begin
            $display("%0t: unexpected word: expected none, ", $time,
                     "actual split %0d depths %0d/%0d error %0d done %0d",
                     rsp_chan.split_here, rsp_chan.section_depth_now,
                     rsp_chan.vector_depth_now, rsp_chan.error_code, rsp_chan.text_done);
            mismatch_count++;
         end else begin
            want = expected_words.pop_front();
            compare_field("split_here", want.split_here, rsp_chan.split_here);
            compare_field("section_depth_now", want.section_depth_now,
                          rsp_chan.section_depth_now);
            compare_field("vector_depth_now", want.vector_depth_now, rsp_chan.vector_depth_now);
            compare_field("error_code", want.error_code, rsp_chan.error_code);
            compare_field("text_done", want.text_done, rsp_chan.text_done);
         end
      end
   end

   // Ends the run if no word moves on any channel for too long.
   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)
          || (csr_chan.valid && csr_chan.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == QUIET_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      reset                = 1'b1;
      req_chan.valid       = 1'b0;
      req_chan.text_byte   = 8'h00;
      req_chan.end_of_text = 1'b0;
      rsp_chan.ready       = 1'b0;
      csr_chan.valid       = 1'b0;
      csr_chan.index       = CSR_SECTION_OPEN;
      csr_chan.data        = 8'h00;
      chars                = DEFAULT_CHARS;
      section_level        = DEPTH_ZERO;
      vector_level         = DEPTH_ZERO;
      text_error           = ERR_NONE;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      test_default_chars();
      test_depth_overflow();
      test_shared_chars();
      test_backpressure();
      test_random_texts();

      drain_results();
      if (mismatch_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
